@@ sv/sfst_pkg.sv @@
// Shared types, constants and helpers for the symmetric flow steering table.
`timescale 1ns / 1ps
`default_nettype none
package sfst_pkg;

    // Default configuration
    localparam int NUM_SETS_DEF    = 256;
    localparam int NUM_WAYS_DEF    = 4;
    localparam int NUM_WORKERS_DEF = 8;
    localparam int NUM_SLOTS_DEF   = 4;
    localparam int QUEUE_DEPTH     = 2;

    // Hash finalizer multipliers
    localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

    // Header checks
    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [3:0]  IP_VER4       = 4'd4;
    localparam logic [13:0] MIN_FRAME_LEN = 14'd34;
    localparam logic [5:0]  MIN_IHL_BYTES = 6'd20;
    localparam logic [14:0] L2_HDR_LEN    = 15'd14;
    localparam logic [14:0] L4_HDR_LEN    = 15'd18;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;

    // Internal widths (sized for the largest legal configuration)
    localparam int IDX_W     = 6;
    localparam int SET_W     = 16;
    localparam int REM_W     = 17;
    localparam int MOD_BITS  = 8;
    localparam int MOD_STEPS = 32 / MOD_BITS;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_NEW      = 2'd1,
        ST_FALLBACK = 2'd2,
        ST_INVALID  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        JOB_INVALID,
        JOB_FALLBACK,
        JOB_TABLE
    } t_job_kind;

    typedef enum logic [2:0] {
        F_IDLE, F_CHECK, F_MIX1, F_MIX2, F_MIX3, F_MOD, F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_CMP, B_SCAN, B_FETCH, B_WRITE
    } t_bstate;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [3:0]  pin_worker;
        logic [13:0]        frame_len;
        logic [15:0]        ethertype;
        logic [7:0]         ver_ihl;
        logic [7:0]         protocol;
        logic [31:0]        src_addr;
        logic [31:0]        dst_addr;
        logic [31:0]        l4_ports;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] core_index;
    } t_out;

    // Classified item handed from front to back
    typedef struct packed {
        t_job_kind          kind;
        logic               tx;
        logic               hint_ok;
        logic [IDX_W-1:0]   hint;
        logic [63:0]        key_a;
        logic [39:0]        key_p;
        logic [SET_W-1:0]   set;
        logic [2:0]         fb_idx;
    } t_job;

    // One way of the flow table
    typedef struct packed {
        logic               valid;
        logic [63:0]        addrs;
        logic [39:0]        ports_proto;
        logic [IDX_W-1:0]   worker;
        logic [IDX_W-1:0]   slot;
    } t_entry;

    // One bit of a restoring remainder: remainder stays below the modulus
    function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] r,
                                                  input logic b,
                                                  input logic [REM_W-1:0] m);
        logic [REM_W-1:0] t;
        t = {r[REM_W-2:0], b};
        mod_step = (t >= m) ? t - m : t;
    endfunction

endpackage
`default_nettype wire

@@ sv/symmetric_flow_steering_table.sv @@
// Top level of the symmetric flow steering table.
//
// Usage: drive i_item with one frame's header fields and raise i_start; the
// item transfers at a rising edge where i_start is high and o_busy is low.
// Each item yields exactly one result on o_result, marked by o_strobe for a
// single cycle; the receiver cannot stall it and must take it then.
// Front end: a valid header steps through the check, the hash states F_MIX1,
// F_MIX2 and F_MIX3, the remainder state F_MOD for each eight-bit digit, the
// push, and the idle state that takes the next transfer; a header rejected at
// the check goes straight to the push. The push waits while the queue is full.
// Back end, after a job leaves the 2-entry queue: invalid or hash-only items
// are answered from the idle state, a table hit or full set from the compare
// state, and an insert after the compare, the load scan (which reads one
// worker and one slot counter per cycle), the fetch and the write states.
// Front and back overlap through the queue, so steady throughput is set by
// the slower of the two.
// After reset a clearing pass zeroes the table and load counters; o_busy
// stays high during it.
`timescale 1ns / 1ps
`default_nettype none
module symmetric_flow_steering_table #(
    parameter int NUM_SETS    = sfst_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = sfst_pkg::NUM_WAYS_DEF,
    parameter int NUM_WORKERS = sfst_pkg::NUM_WORKERS_DEF,
    parameter int NUM_SLOTS   = sfst_pkg::NUM_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire sfst_pkg::t_in  i_item,
    output logic                o_busy,
    output logic                o_strobe,
    output sfst_pkg::t_out      o_result
);
    import sfst_pkg::*;

    logic   f_busy, clearing;
    logic   push, full, pop, empty;
    t_job   push_job, head_job;

    assign o_busy = f_busy || clearing;

    // Classification and hashing
    sfst_front #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WORKERS (NUM_WORKERS),
        .NUM_SLOTS   (NUM_SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_hold  (clearing),
        .i_item  (i_item),
        .o_busy  (f_busy),
        .o_push  (push),
        .o_job   (push_job),
        .i_full  (full)
    );

    // Decoupling queue
    sfst_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    // Table lookup and insert
    sfst_back #(
        .NUM_SETS    (NUM_SETS),
        .NUM_WAYS    (NUM_WAYS),
        .NUM_WORKERS (NUM_WORKERS),
        .NUM_SLOTS   (NUM_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule
`default_nettype wire

@@ sv/sfst_front.sv @@
// Front end: header check, symmetric key ordering, fmix32 hash and remainders.
`timescale 1ns / 1ps
`default_nettype none
module sfst_front #(
    parameter int NUM_SETS    = sfst_pkg::NUM_SETS_DEF,
    parameter int NUM_WORKERS = sfst_pkg::NUM_WORKERS_DEF,
    parameter int NUM_SLOTS   = sfst_pkg::NUM_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic          i_hold,
    input  wire sfst_pkg::t_in i_item,
    output logic               o_busy,
    output logic               o_push,
    output sfst_pkg::t_job     o_job,
    input  wire logic          i_full
);
    import sfst_pkg::*;

    localparam int CNT_W = $clog2(MOD_STEPS);

    t_fstate            r_state, n_state;
    t_in                r_in;
    logic [31:0]        r_x, n_x;
    logic [63:0]        r_key_a;
    logic [39:0]        r_key_p;
    t_job_kind          r_kind;
    logic               r_tx, r_hint_ok;
    logic [IDX_W-1:0]   r_hint;
    logic [REM_W-1:0]   r_rs, r_rw, r_rt, n_rs, n_rw, n_rt;
    logic [CNT_W-1:0]   r_cnt;

    logic               accept;
    logic [5:0]         ihl_bytes;
    logic               bad_hdr, is_l4, bad_l4, swap;
    logic [15:0]        sp, dp, osp, odp;
    logic [31:0]        osa, oda;

    assign o_busy = (r_state != F_IDLE);
    assign accept = i_start && (r_state == F_IDLE) && !i_hold;

    // Header validation and direction-independent key ordering
    always_comb begin
        ihl_bytes = {r_in.ver_ihl[3:0], 2'b00};
        bad_hdr   = (r_in.frame_len < MIN_FRAME_LEN) || (r_in.ethertype != ETH_IPV4) ||
                    (r_in.ver_ihl[7:4] != IP_VER4) || (ihl_bytes < MIN_IHL_BYTES) ||
                    ({1'b0, r_in.frame_len} < L2_HDR_LEN + {9'b0, ihl_bytes});
        is_l4     = (r_in.protocol == PROTO_TCP) || (r_in.protocol == PROTO_UDP);
        bad_l4    = is_l4 && ({1'b0, r_in.frame_len} < L4_HDR_LEN + {9'b0, ihl_bytes});
        sp        = is_l4 ? r_in.l4_ports[31:16] : 16'd0;
        dp        = is_l4 ? r_in.l4_ports[15:0]  : 16'd0;
        swap      = is_l4 && ((r_in.src_addr > r_in.dst_addr) ||
                    ((r_in.src_addr == r_in.dst_addr) && (sp > dp)));
        osa       = swap ? r_in.dst_addr : r_in.src_addr;
        oda       = swap ? r_in.src_addr : r_in.dst_addr;
        osp       = swap ? dp : sp;
        odp       = swap ? sp : dp;
    end

    // Hash datapath and remainder digits, eight bits per cycle
    always_comb begin
        logic [REM_W-1:0] rs, rw, rt;
        rs  = r_rs;
        rw  = r_rw;
        rt  = r_rt;
        n_x = r_x;
        for (int k = 0; k < MOD_BITS; k++) begin
            rs = mod_step(rs, r_x[31-k], REM_W'(NUM_SETS));
            rw = mod_step(rw, r_x[31-k], REM_W'(NUM_WORKERS));
            rt = mod_step(rt, r_x[31-k], REM_W'(NUM_SLOTS));
        end
        n_rs = rs;
        n_rw = rw;
        n_rt = rt;
        case (r_state)
            F_CHECK: n_x = osa ^ oda ^ {osp, odp} ^ {24'd0, r_in.protocol};
            F_MIX1:  n_x = 32'((r_x ^ (r_x >> 16)) * MIX_C1);
            F_MIX2:  n_x = 32'((r_x ^ (r_x >> 13)) * MIX_C2);
            F_MIX3:  n_x = r_x ^ (r_x >> 16);
            F_MOD:   n_x = r_x << MOD_BITS;
            default: n_x = r_x;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE:  if (accept) begin
                n_state = F_CHECK;
            end
            F_CHECK: n_state = (bad_hdr || bad_l4) ? F_PUSH : F_MIX1;
            F_MIX1:  n_state = F_MIX2;
            F_MIX2:  n_state = F_MIX3;
            F_MIX3:  n_state = F_MOD;
            F_MOD:   if (r_cnt == CNT_W'(MOD_STEPS - 1)) begin
                n_state = F_PUSH;
            end
            F_PUSH:  if (!i_full) begin
                o_push  = 1'b1;
                n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        if (accept) begin
            r_in <= i_item;
        end
        if (r_state == F_CHECK) begin
            r_key_a   <= {osa, oda};
            r_key_p   <= {osp, odp, r_in.protocol};
            r_tx      <= (r_in.mode != 2'd0);
            r_hint_ok <= !r_in.pin_worker[3] && (int'(r_in.pin_worker[2:0]) < NUM_WORKERS);
            r_hint    <= IDX_W'(r_in.pin_worker[2:0]);
            if (bad_hdr || bad_l4) begin
                r_kind <= JOB_INVALID;
            end else if (r_in.mode == 2'd1 || !is_l4) begin
                r_kind <= JOB_FALLBACK;
            end else begin
                r_kind <= JOB_TABLE;
            end
        end
        if (r_state == F_MIX3) begin
            r_rs  <= '0;
            r_rw  <= '0;
            r_rt  <= '0;
            r_cnt <= '0;
        end else if (r_state == F_MOD) begin
            r_rs  <= n_rs;
            r_rw  <= n_rw;
            r_rt  <= n_rt;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Job to the queue
    always_comb begin
        o_job         = '0;
        o_job.kind    = r_kind;
        o_job.tx      = r_tx;
        o_job.hint_ok = r_hint_ok;
        o_job.hint    = r_hint;
        o_job.key_a   = r_key_a;
        o_job.key_p   = r_key_p;
        o_job.set     = SET_W'(r_rs);
        o_job.fb_idx  = r_tx ? r_rt[2:0] : r_rw[2:0];
    end

endmodule
`default_nettype wire

@@ sv/sfst_fifo.sv @@
// Small job queue between the front end and the table engine.
`timescale 1ns / 1ps
`default_nettype none
module sfst_fifo #(
    parameter int DEPTH = sfst_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sfst_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output sfst_pkg::t_job      o_job,
    output logic                o_empty
);
    import sfst_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

@@ sv/sfst_back.sv @@
// Table engine: set lookup, insert with least-loaded scan, load counters.
`timescale 1ns / 1ps
`default_nettype none
module sfst_back #(
    parameter int NUM_SETS    = sfst_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS    = sfst_pkg::NUM_WAYS_DEF,
    parameter int NUM_WORKERS = sfst_pkg::NUM_WORKERS_DEF,
    parameter int NUM_SLOTS   = sfst_pkg::NUM_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire sfst_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_strobe,
    output sfst_pkg::t_out      o_result
);
    import sfst_pkg::*;

    localparam int SI     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WI     = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int TI     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int MAXWT  = (NUM_WORKERS > NUM_SLOTS) ? NUM_WORKERS : NUM_SLOTS;
    localparam int SCAN_N = MAXWT - 1;
    localparam int CNT_W  = $clog2(SCAN_N + 2);
    localparam int CLR_N  = (NUM_SETS > MAXWT) ? NUM_SETS : MAXWT;
    localparam int CLR_W  = $clog2(CLR_N + 1);

    // Memories
    t_entry [NUM_WAYS-1:0] r_tab [NUM_SETS];
    t_entry [NUM_WAYS-1:0] r_row;
    logic [31:0]           r_wload [NUM_WORKERS];
    logic [31:0]           r_sload [NUM_SLOTS];
    logic [31:0]           r_wq, r_sq;

    // Control and payload registers
    t_bstate            r_state, n_state;
    logic [CLR_W-1:0]   r_clr_idx, n_clr_idx;
    logic [WI-1:0]      r_wcur, n_wcur, r_bw, n_bw, r_wptr, n_wptr, r_w, n_w;
    logic [TI-1:0]      r_scur, n_scur, r_bt, n_bt, r_sptr, n_sptr;
    logic [31:0]        r_bwl, n_bwl, r_btl, n_btl;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [WAY_W-1:0]   r_way, n_way;
    t_job               r_job, n_job;
    logic               r_strobe, n_strobe;
    t_out               r_out, n_out;

    // Memory port controls
    logic                   tab_re, tab_we;
    logic [SI-1:0]          tab_waddr;
    t_entry [NUM_WAYS-1:0]  tab_wdata, new_row;
    logic                   wl_we, sl_we;
    logic [WI-1:0]          wl_waddr, wl_raddr;
    logic [TI-1:0]          sl_waddr, sl_raddr;
    logic [31:0]            wl_wdata, sl_wdata;

    // Lookup results
    logic               hit, free;
    logic [WAY_W-1:0]   hit_way, free_way;
    t_entry             hit_ent, ins_ent;

    function automatic logic [WI-1:0] nxt_w(input logic [WI-1:0] x);
        nxt_w = (x == WI'(NUM_WORKERS - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [TI-1:0] nxt_s(input logic [TI-1:0] x);
        nxt_s = (x == TI'(NUM_SLOTS - 1)) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        sat_inc = (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

    assign o_clearing = (r_state == B_CLEAR);
    assign o_strobe   = r_strobe;
    assign o_result   = r_out;

    // Way compare over the fetched set
    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int k = 0; k < NUM_WAYS; k++) begin
            if (r_row[k].valid && r_row[k].addrs == r_job.key_a &&
                r_row[k].ports_proto == r_job.key_p && !hit) begin
                hit     = 1'b1;
                hit_way = WAY_W'(k);
            end
            if (!r_row[k].valid && !free) begin
                free     = 1'b1;
                free_way = WAY_W'(k);
            end
        end
        hit_ent             = r_row[hit_way];
        ins_ent.valid       = 1'b1;
        ins_ent.addrs       = r_job.key_a;
        ins_ent.ports_proto = r_job.key_p;
        ins_ent.worker      = IDX_W'(r_w);
        ins_ent.slot        = IDX_W'(r_bt);
        new_row             = r_row;
        new_row[r_way]      = ins_ent;
    end

    // Engine sequencing
    always_comb begin
        n_state   = r_state;
        n_clr_idx = r_clr_idx;
        n_wcur    = r_wcur;
        n_scur    = r_scur;
        n_job     = r_job;
        n_way     = r_way;
        n_bw      = r_bw;
        n_bwl     = r_bwl;
        n_bt      = r_bt;
        n_btl     = r_btl;
        n_wptr    = r_wptr;
        n_sptr    = r_sptr;
        n_cnt     = r_cnt;
        n_w       = r_w;
        n_strobe  = 1'b0;
        n_out     = r_out;
        o_pop     = 1'b0;
        tab_re    = 1'b0;
        tab_we    = 1'b0;
        tab_waddr = r_job.set[SI-1:0];
        tab_wdata = new_row;
        wl_we     = 1'b0;
        wl_waddr  = r_w;
        wl_wdata  = sat_inc(r_wq);
        sl_we     = 1'b0;
        sl_waddr  = r_bt;
        sl_wdata  = sat_inc(r_sq);
        wl_raddr  = r_wcur;
        sl_raddr  = r_scur;
        case (r_state)
            B_CLEAR: begin
                tab_we    = (r_clr_idx < CLR_W'(NUM_SETS));
                tab_waddr = r_clr_idx[SI-1:0];
                tab_wdata = '0;
                wl_we     = (r_clr_idx < CLR_W'(NUM_WORKERS));
                wl_waddr  = r_clr_idx[WI-1:0];
                wl_wdata  = '0;
                sl_we     = (r_clr_idx < CLR_W'(NUM_SLOTS));
                sl_waddr  = r_clr_idx[TI-1:0];
                sl_wdata  = '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == CLR_W'(CLR_N - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    if (i_job.kind == JOB_TABLE) begin
                        tab_re  = 1'b1;
                        n_state = B_CMP;
                    end else if (i_job.kind == JOB_FALLBACK) begin
                        n_strobe         = 1'b1;
                        n_out.status     = ST_FALLBACK;
                        n_out.core_index = i_job.fb_idx;
                    end else begin
                        n_strobe         = 1'b1;
                        n_out.status     = ST_INVALID;
                        n_out.core_index = 3'd0;
                    end
                end
            end
            B_CMP: begin
                if (hit) begin
                    n_strobe         = 1'b1;
                    n_out.status     = ST_HIT;
                    n_out.core_index = r_job.tx ? hit_ent.slot[2:0] : hit_ent.worker[2:0];
                    n_state          = B_IDLE;
                end else if (!free) begin
                    n_strobe         = 1'b1;
                    n_out.status     = ST_FALLBACK;
                    n_out.core_index = r_job.fb_idx;
                    n_state          = B_IDLE;
                end else begin
                    n_way    = free_way;
                    n_bw     = r_wcur;
                    n_bwl    = r_wq;
                    n_bt     = r_scur;
                    n_btl    = r_sq;
                    n_wptr   = nxt_w(r_wcur);
                    n_sptr   = nxt_s(r_scur);
                    wl_raddr = nxt_w(r_wcur);
                    sl_raddr = nxt_s(r_scur);
                    n_cnt    = CNT_W'(1);
                    n_state  = (SCAN_N > 0) ? B_SCAN : B_FETCH;
                end
            end
            B_SCAN: begin
                // Read data belongs to the pointers; first strict minimum wins
                if (r_cnt < CNT_W'(NUM_WORKERS) && r_wq < r_bwl) begin
                    n_bw  = r_wptr;
                    n_bwl = r_wq;
                end
                if (r_cnt < CNT_W'(NUM_SLOTS) && r_sq < r_btl) begin
                    n_bt  = r_sptr;
                    n_btl = r_sq;
                end
                n_wptr   = nxt_w(r_wptr);
                n_sptr   = nxt_s(r_sptr);
                wl_raddr = nxt_w(r_wptr);
                sl_raddr = nxt_s(r_sptr);
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCAN_N)) begin
                    n_state = B_FETCH;
                end
            end
            B_FETCH: begin
                n_w      = r_job.hint_ok ? r_job.hint[WI-1:0] : r_bw;
                wl_raddr = n_w;
                sl_raddr = r_bt;
                n_state  = B_WRITE;
            end
            B_WRITE: begin
                tab_we = 1'b1;
                wl_we  = 1'b1;
                sl_we  = 1'b1;
                if (!r_job.hint_ok) begin
                    n_wcur = nxt_w(r_wcur);
                end
                n_scur           = nxt_s(r_scur);
                n_strobe         = 1'b1;
                n_out.status     = ST_NEW;
                n_out.core_index = r_job.tx ? 3'(r_bt) : 3'(r_w);
                n_state          = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_CLEAR;
            r_clr_idx <= '0;
            r_wcur    <= '0;
            r_scur    <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_wcur    <= n_wcur;
            r_scur    <= n_scur;
            r_strobe  <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_way  <= n_way;
        r_bw   <= n_bw;
        r_bwl  <= n_bwl;
        r_bt   <= n_bt;
        r_btl  <= n_btl;
        r_wptr <= n_wptr;
        r_sptr <= n_sptr;
        r_cnt  <= n_cnt;
        r_w    <= n_w;
        r_out  <= n_out;
    end

    // Flow table memory
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_waddr] <= tab_wdata;
        end
        if (tab_re) begin
            r_row <= r_tab[i_job.set[SI-1:0]];
        end
    end

    // Load counter memories
    always_ff @(posedge i_clk) begin
        if (wl_we) begin
            r_wload[wl_waddr] <= wl_wdata;
        end
        if (sl_we) begin
            r_sload[sl_waddr] <= sl_wdata;
        end
        r_wq <= r_wload[wl_raddr];
        r_sq <= r_sload[sl_raddr];
    end

endmodule
`default_nettype wire

@@ sv/sfst_checker.sv @@
// Port-level checker for the flow steering table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sfst_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_start,
    input wire logic           o_busy,
    input wire logic           o_strobe,
    input wire sfst_pkg::t_out o_result
);
    import sfst_pkg::*;

    // Reset leaves no result pending
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");

    // Reset starts the clearing pass, which holds off transfers
    a_rst_busy: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("not busy after reset");

    // A transferred item occupies the front end
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("not busy after transfer");

    // Invalid headers report index zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_INVALID) |-> (o_result.core_index == 3'd0))
        else $error("invalid header with nonzero index");

endmodule

bind symmetric_flow_steering_table sfst_checker u_sfst_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
`default_nettype wire

@@ tb/tb_symmetric_flow_steering_table.sv @@
// Self-checking testbench for the symmetric flow steering table.
`timescale 1ns / 1ps
`default_nettype none
module tb_symmetric_flow_steering_table;
    import sfst_pkg::*;

    localparam int SETS    = NUM_SETS_DEF;
    localparam int WAYS    = NUM_WAYS_DEF;
    localparam int WORKERS = NUM_WORKERS_DEF;
    localparam int SLOTS   = NUM_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IN_W    = $bits(t_in);

    logic  clk;
    logic  rst_n;
    logic  start;
    t_in   item;
    logic  busy;
    logic  strobe;
    t_out  result;

    symmetric_flow_steering_table dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_item(item),
        .o_busy(busy), .o_strobe(strobe), .o_result(result)
    );

    // Predictor state
    logic        flow_valid [SETS*WAYS];
    logic [63:0] flow_addrs [SETS*WAYS];
    logic [39:0] flow_ports [SETS*WAYS];
    logic [2:0]  flow_worker[SETS*WAYS];
    logic [1:0]  flow_slot  [SETS*WAYS];
    logic [31:0] worker_load[WORKERS];
    logic [31:0] slot_load  [SLOTS];
    int          worker_cur;
    int          slot_cur;

    t_in  pending_frames[$];
    t_out expected_steer[$];
    int   errors;
    int   cycles;
    int   in_gap;
    bit   stim_done;
    bit   hold_for_drain;

    function automatic logic [31:0] fmix(input logic [31:0] v);
        logic [31:0] x;
        x = v ^ (v >> 16);
        x = x * MIX_C1;
        x = x ^ (x >> 13);
        x = x * MIX_C2;
        return x ^ (x >> 16);
    endfunction

    // Compute the steering result for one frame and update the table
    function automatic t_out steer_frame(input t_in f);
        t_out        r;
        logic [31:0] sa, da, h, t;
        logic [15:0] sp, dp, t16;
        int          ihl, rng, base, empty, wc, tc, bw, bt, c, w;
        bit          l4, tx, hint_ok;
        r.status = ST_INVALID;
        r.core_index = 3'd0;
        sa = f.src_addr; da = f.dst_addr; sp = 16'd0; dp = 16'd0;
        tx = (f.mode != 0);
        hint_ok = !f.pin_worker[3] && int'(f.pin_worker[2:0]) < WORKERS;
        ihl = f.ver_ihl[3:0] * 4;
        if (f.frame_len < 34 || f.ethertype != ETH_IPV4 || f.ver_ihl[7:4] != IP_VER4
                || ihl < 20 || f.frame_len < 14 + ihl)
            return r;
        l4 = (f.protocol == PROTO_TCP || f.protocol == PROTO_UDP);
        if (l4) begin
            if (f.frame_len < 18 + ihl)
                return r;
            sp = f.l4_ports[31:16];
            dp = f.l4_ports[15:0];
            if (sa > da || (sa == da && sp > dp)) begin
                t = sa; sa = da; da = t;
                t16 = sp; sp = dp; dp = t16;
            end
        end
        h = fmix(sa ^ da ^ {sp, dp} ^ {24'd0, f.protocol});
        rng = tx ? SLOTS : WORKERS;
        r.status = ST_FALLBACK;
        r.core_index = 3'(h % rng);
        if (f.mode == 1 || !l4)
            return r;
        base = int'(h % SETS) * WAYS;
        empty = -1;
        for (int i = 0; i < WAYS; i++) begin
            if (!flow_valid[base+i]) begin
                if (empty < 0) empty = i;
            end else if (flow_addrs[base+i] == {sa, da}
                    && flow_ports[base+i] == {sp, dp, f.protocol}) begin
                r.status = ST_HIT;
                r.core_index = tx ? 3'(flow_slot[base+i]) : flow_worker[base+i];
                return r;
            end
        end
        if (empty < 0)
            return r;
        wc = worker_cur; tc = slot_cur; bw = wc; bt = tc;
        if (!hint_ok) worker_cur = (wc + 1) % WORKERS;
        slot_cur = (tc + 1) % SLOTS;
        for (int i = 1; i < WORKERS; i++) begin
            c = (wc + i) % WORKERS;
            if (worker_load[c] < worker_load[bw]) bw = c;
        end
        for (int i = 1; i < SLOTS; i++) begin
            c = (tc + i) % SLOTS;
            if (slot_load[c] < slot_load[bt]) bt = c;
        end
        w = hint_ok ? int'(f.pin_worker[2:0]) : bw;
        flow_valid[base+empty]  = 1;
        flow_addrs[base+empty]  = {sa, da};
        flow_ports[base+empty]  = {sp, dp, f.protocol};
        flow_worker[base+empty] = 3'(w);
        flow_slot[base+empty]   = 2'(bt);
        if (worker_load[w] != '1) worker_load[w]++;
        if (slot_load[bt] != '1) slot_load[bt]++;
        r.status = ST_NEW;
        r.core_index = tx ? 3'(bt) : 3'(w);
        return r;
    endfunction

    // Random valid TCP/UDP frame from a small flow pool, so hits and full sets occur
    function automatic t_in flow_frame(input int pool);
        t_in f;
        int  k;
        k = $urandom_range(0, pool);
        f.mode        = 2'($urandom_range(0, 3));
        f.pin_worker  = ($urandom_range(0, 2) == 0) ? 4'($urandom) : -4'sd1;
        f.ver_ihl     = {4'd4, 4'($urandom_range(5, 15))};
        f.frame_len   = 14'($urandom_range(18 + 4 * f.ver_ihl[3:0], 16383));
        f.ethertype   = ETH_IPV4;
        f.protocol    = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        f.src_addr    = 32'h0a00_0000 + k;
        f.dst_addr    = 32'hc0a8_0000 + (k * 7);
        f.l4_ports    = {16'(1000 + k), 16'd80};
        // reverse direction of the same flow
        if ($urandom_range(0, 1)) begin
            f.src_addr = 32'hc0a8_0000 + (k * 7);
            f.dst_addr = 32'h0a00_0000 + k;
            f.l4_ports = {16'd80, 16'(1000 + k)};
        end
        return f;
    endfunction

    function automatic t_in noise_frame();
        t_in f;
        f = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 1)) begin
            f.ethertype = ETH_IPV4;
            f.ver_ihl[7:4] = IP_VER4;
        end
        return f;
    endfunction

    // Clock
    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Stimulus
    initial begin
        t_in f;
        f = '0;
        f.ethertype = ETH_IPV4; f.ver_ihl = 8'h45; f.frame_len = 14'd64;
        f.protocol = PROTO_TCP; f.src_addr = 32'h0102_0304; f.dst_addr = 32'h0506_0708;
        f.l4_ports = 32'h1234_0050; f.pin_worker = -4'sd1;
        for (int m = 0; m < 4; m++) begin
            f.mode = 2'(m);
            pending_frames.push_back(f);
        end
        // reverse direction hits
        f.mode = 2'd0; f.src_addr = 32'h0506_0708; f.dst_addr = 32'h0102_0304;
        f.l4_ports = 32'h0050_1234;
        pending_frames.push_back(f);
        // equal addresses, port swap; hints in and out of range
        f.src_addr = 32'hffff_ffff; f.dst_addr = 32'hffff_ffff; f.l4_ports = 32'hffff_0000;
        f.pin_worker = 4'sd7; pending_frames.push_back(f);
        f.l4_ports = 32'h0000_ffff; f.protocol = PROTO_UDP; f.pin_worker = 4'sd0;
        pending_frames.push_back(f);
        f.src_addr = 32'd0; f.pin_worker = -4'sd8; pending_frames.push_back(f);
        // non-TCP/UDP fallback
        f.protocol = 8'hff; f.mode = 2'd2; pending_frames.push_back(f);
        f.protocol = 8'd1; f.mode = 2'd0; pending_frames.push_back(f);
        // invalid headers, with valid frames at the exact minimum lengths
        f.protocol = PROTO_TCP;
        f.frame_len = 14'd33; pending_frames.push_back(f);
        f.frame_len = 14'h3fff; f.ethertype = 16'h86dd; pending_frames.push_back(f);
        f.ethertype = ETH_IPV4; f.ver_ihl = 8'h65; pending_frames.push_back(f);
        f.ver_ihl = 8'h44; pending_frames.push_back(f);
        f.ver_ihl = 8'h4f; f.frame_len = 14'd73; pending_frames.push_back(f);
        f.frame_len = 14'd77; pending_frames.push_back(f);
        f.frame_len = 14'd78; pending_frames.push_back(f);
        f.protocol = 8'd2; f.frame_len = 14'd74; pending_frames.push_back(f);
        f.frame_len = 14'd0; pending_frames.push_back(f);
        // flows from a small then a large pool, with noise; a hint change alone only hits
        for (int i = 0; i < 480; i++) begin
            if ($urandom_range(0, 9) < 8)
                pending_frames.push_back(flow_frame(i < 300 ? 40 : 1500));
            else
                pending_frames.push_back(noise_frame());
        end
    end

    // Reset and driver
    initial begin
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 0;
            item <= '0;
            in_gap <= 0;
            stim_done <= 0;
            hold_for_drain <= 0;
        end else if (start && busy) begin
            // hold the request until it transfers
        end else begin
            if (start)
                expected_steer.push_back(steer_frame(item));
            if (hold_for_drain && (expected_steer.size() != 0 || start)) begin
                start <= 0;
            end else if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                start <= 0;
            end else if (pending_frames.size() == 0) begin
                start <= 0;
                stim_done <= 1;
            end else begin
                hold_for_drain <= (pending_frames.size() == 300);
                item <= pending_frames.pop_front();
                start <= 1;
                if ($urandom_range(0, 7) == 0)
                    in_gap <= $urandom_range(1, 30);
            end
        end
    end

    // Monitor
    always @(posedge clk) begin
        t_out want;
        if (rst_n && strobe) begin
            if (expected_steer.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                errors <= errors + 1;
            end else begin
                want = expected_steer.pop_front();
                if (want.status != result.status || want.core_index != result.core_index) begin
                    $display("%0t: mismatch, expected status %0d core %0d, actual status %0d core %0d",
                             $time, want.status, want.core_index, result.status,
                             result.core_index);
                    errors <= errors + 1;
                end
            end
        end
    end

    // End of run
    initial begin
        errors = 0;
        cycles = 0;
        worker_cur = 0;
        slot_cur = 0;
        foreach (flow_valid[i]) flow_valid[i] = 0;
        foreach (worker_load[i]) worker_load[i] = 0;
        foreach (slot_load[i]) slot_load[i] = 0;
        while (!(stim_done && expected_steer.size() == 0) && cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_symmetric_flow_steering_table: errors");
        end else begin
            repeat (40) @(posedge clk);
            if (errors == 0)
                $display("tb_symmetric_flow_steering_table: clean");
            else
                $display("tb_symmetric_flow_steering_table: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ symmetric_flow_steering_table.f @@
sv/sfst_pkg.sv
sv/sfst_front.sv
sv/sfst_fifo.sv
sv/sfst_back.sv
sv/symmetric_flow_steering_table.sv
sv/sfst_checker.sv
tb/tb_symmetric_flow_steering_table.sv
